// ===== hw/rtl/gpr_pkg.sv =====
package gpr_pkg;

    // Screen geometry in pixels.
    localparam int SCREEN_WIDTH  = 1920;
    localparam int SCREEN_HEIGHT = 1080;
    localparam int SCREEN_X_HALF = SCREEN_WIDTH / 2;

    // Approximations of the cosine and sine of 30 degrees in signed Q2.30.
    localparam logic signed [31:0] ISO_COS_Q30 = 32'sd929887577;
    localparam logic signed [31:0] ISO_SIN_Q30 = 32'sd536871121;

    // Pipeline depth from the input register to the output register.
    localparam int NUM_STAGES = 11;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        REG_ZOOM           = 4'd0,
        REG_HEIGHT_SCALE   = 4'd1,
        REG_SINCOS_ABOUT_X = 4'd2,
        REG_SINCOS_ABOUT_Y = 4'd3,
        REG_SINCOS_ABOUT_Z = 4'd4,
        REG_ISO_MODE       = 4'd5,
        REG_MAP_SIZE       = 4'd6,
        REG_SCREEN_SHIFT   = 4'd7
    } cfg_reg_t;

    // Full signed 32 by 32 product.
    function automatic logic signed [63:0] mul_s32(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        mul_s32 = a * b;
    endfunction

    // Divide by 2^30 truncating toward zero, then keep the low 32 bits.
    function automatic logic signed [31:0] q30_trunc(input logic signed [65:0] s);
        logic signed [65:0] floor_q;
        logic [31:0]        q;
        floor_q = s >>> 30;
        q = floor_q[31:0];
        if (s[65] && (s[29:0] != 30'd0))
        begin
            q = q + 32'd1;
        end
        q30_trunc = signed'(q);
    endfunction

endpackage

// ===== hw/rtl/gpr_if.sv =====
// Point request channel.
interface gpr_point_if;
    logic               valid;
    logic               ready;
    logic [15:0]        grid_col;
    logic [15:0]        grid_row;
    logic signed [15:0] height_z;
    logic [23:0]        point_color;

    modport source (output valid, output grid_col, output grid_row, output height_z,
                    output point_color, input ready);
    modport sink   (input valid, input grid_col, input grid_row, input height_z,
                    input point_color, output ready);
endinterface

// Projected point request channel.
interface gpr_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic signed [31:0] depth;
    logic [23:0]        color_out;
    logic               needs_default_color;

    modport source (output valid, output screen_x, output screen_y, output depth,
                    output color_out, output needs_default_color, input ready);
    modport sink   (input valid, input screen_x, input screen_y, input depth,
                    input color_out, input needs_default_color, output ready);
endinterface

// Configuration write channel.
interface gpr_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/grid_point_rotate_project_core.sv =====
// Throughput: one point per cycle while the result is taken; the eleven-stage pipeline carries a
// valid bit per stage and only stages behind a stalled result hold, so bubbles are squeezed out.
// Reset (rst_n low, asynchronous) clears every stage valid bit and loads the
// configuration registers with their defaults; configuration writes are always accepted.
module grid_point_rotate_project_core import gpr_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    gpr_point_if.sink    point,
    gpr_result_if.source result,
    gpr_cfg_if.sink      cfg
);

    // Configuration registers.
    logic [10:0] zoom_reg;
    logic [15:0] hscale_reg;
    logic [63:0] rot_x_reg;
    logic [63:0] rot_y_reg;
    logic [63:0] rot_z_reg;
    logic        iso_reg;
    logic [31:0] map_reg;
    logic [63:0] shift_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_reg   <= 11'd1;
            hscale_reg <= 16'd256;
            rot_x_reg  <= 64'd1073741824;
            rot_y_reg  <= 64'd1073741824;
            rot_z_reg  <= 64'd1073741824;
            iso_reg    <= 1'b1;
            map_reg    <= 32'd0;
            shift_reg  <= 64'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_ZOOM:           zoom_reg   <= cfg.data[10:0];
                REG_HEIGHT_SCALE:   hscale_reg <= cfg.data[15:0];
                REG_SINCOS_ABOUT_X: rot_x_reg  <= cfg.data;
                REG_SINCOS_ABOUT_Y: rot_y_reg  <= cfg.data;
                REG_SINCOS_ABOUT_Z: rot_z_reg  <= cfg.data;
                REG_ISO_MODE:       iso_reg    <= cfg.data[0];
                REG_MAP_SIZE:       map_reg    <= cfg.data[31:0];
                REG_SCREEN_SHIFT:   shift_reg  <= cfg.data;
                default:            ;
            endcase
        end
    end

    logic signed [31:0] sin_x, cos_x, sin_y, cos_y, sin_z, cos_z;
    assign sin_x = signed'(rot_x_reg[63:32]);
    assign cos_x = signed'(rot_x_reg[31:0]);
    assign sin_y = signed'(rot_y_reg[63:32]);
    assign cos_y = signed'(rot_y_reg[31:0]);
    assign sin_z = signed'(rot_z_reg[63:32]);
    assign cos_z = signed'(rot_z_reg[31:0]);

    // Offsets that depend only on configuration, registered once per cycle.
    logic [25:0] cw_reg;
    logic [25:0] ch_reg;
    logic [31:0] xoff_reg;
    logic [31:0] yoff_reg;
    logic [26:0] map_w_zoom;
    logic [26:0] map_h_zoom;
    logic [26:0] yoff_base;

    always_comb
    begin
        map_w_zoom = map_reg[31:16] * zoom_reg;
        map_h_zoom = map_reg[15:0] * zoom_reg;
        yoff_base  = 27'(SCREEN_HEIGHT) + 27'(map_reg[15:1]) * 27'(zoom_reg);
    end

    always_ff @(posedge clk)
    begin
        cw_reg   <= map_w_zoom[26:1];
        ch_reg   <= map_h_zoom[26:1];
        xoff_reg <= 32'(SCREEN_X_HALF) + shift_reg[63:32];
        yoff_reg <= 32'(yoff_base[26:1]) + shift_reg[31:0];
    end

    // Stage enables: a stage loads when it is empty or the stage after it moves.
    logic [NUM_STAGES-1:0] v_reg;
    logic [NUM_STAGES-1:0] en;

    always_comb
    begin
        en[NUM_STAGES-1] = !v_reg[NUM_STAGES-1] || result.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    assign point.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= point.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // Color travels alongside the coordinates.
    logic [23:0] color_reg [NUM_STAGES];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            color_reg[0] <= point.point_color;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                color_reg[k] <= color_reg[k-1];
            end
        end
    end

    // Stage 0: scale by zoom and by the Q8.8 height factor.
    logic [26:0]        s0_x_reg;
    logic [26:0]        s0_y_reg;
    logic signed [32:0] s0_zp_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_x_reg  <= point.grid_col * zoom_reg;
            s0_y_reg  <= point.grid_row * zoom_reg;
            s0_zp_reg <= point.height_z * signed'({1'b0, hscale_reg});
        end
    end

    // Stage 1: center on the map and finish the height division toward zero.
    logic signed [32:0] z_floor;
    logic               z_neg_frac;
    logic signed [31:0] s1_z_next;
    logic signed [31:0] s1_x_reg;
    logic signed [31:0] s1_y_reg;
    logic signed [31:0] s1_z_reg;

    always_comb
    begin
        z_floor    = s0_zp_reg >>> 8;
        z_neg_frac = s0_zp_reg[32] && (s0_zp_reg[7:0] != 8'd0);
        s1_z_next  = signed'(z_floor[31:0] + 32'(z_neg_frac));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_x_reg <= signed'(32'(s0_x_reg) - 32'(cw_reg));
            s1_y_reg <= signed'(32'(s0_y_reg) - 32'(ch_reg));
            s1_z_reg <= s1_z_next;
        end
    end

    // Stage 2: products for the rotation about X.
    logic signed [63:0] s2_ycx_reg, s2_zsx_reg, s2_ysx_reg, s2_zcx_reg;
    logic signed [31:0] s2_x_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_ycx_reg <= mul_s32(s1_y_reg, cos_x);
            s2_zsx_reg <= mul_s32(s1_z_reg, sin_x);
            s2_ysx_reg <= mul_s32(s1_y_reg, sin_x);
            s2_zcx_reg <= mul_s32(s1_z_reg, cos_x);
            s2_x_reg   <= s1_x_reg;
        end
    end

    // Stage 3: sums for the rotation about X.
    logic signed [31:0] s3_x_reg, s3_y1_reg, s3_z1_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_y1_reg <= q30_trunc(66'(s2_ycx_reg) + 66'(s2_zsx_reg));
            s3_z1_reg <= q30_trunc(66'(s2_zcx_reg) - 66'(s2_ysx_reg));
            s3_x_reg  <= s2_x_reg;
        end
    end

    // Stage 4: products for the rotation about Y.
    logic signed [63:0] s4_xcy_reg, s4_zsy_reg, s4_xsy_reg, s4_zcy_reg;
    logic signed [31:0] s4_y1_reg;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_xcy_reg <= mul_s32(s3_x_reg, cos_y);
            s4_zsy_reg <= mul_s32(s3_z1_reg, sin_y);
            s4_xsy_reg <= mul_s32(s3_x_reg, sin_y);
            s4_zcy_reg <= mul_s32(s3_z1_reg, cos_y);
            s4_y1_reg  <= s3_y1_reg;
        end
    end

    // Stage 5: sums for the rotation about Y.
    logic signed [31:0] s5_x1_reg, s5_y1_reg, s5_z2_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_x1_reg <= q30_trunc(66'(s4_xcy_reg) + 66'(s4_zsy_reg));
            s5_z2_reg <= q30_trunc(66'(s4_zcy_reg) - 66'(s4_xsy_reg));
            s5_y1_reg <= s4_y1_reg;
        end
    end

    // Stage 6: products for the rotation about Z.
    logic signed [63:0] s6_xcz_reg, s6_ysz_reg, s6_xsz_reg, s6_ycz_reg;
    logic signed [31:0] s6_z2_reg;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_xcz_reg <= mul_s32(s5_x1_reg, cos_z);
            s6_ysz_reg <= mul_s32(s5_y1_reg, sin_z);
            s6_xsz_reg <= mul_s32(s5_x1_reg, sin_z);
            s6_ycz_reg <= mul_s32(s5_y1_reg, cos_z);
            s6_z2_reg  <= s5_z2_reg;
        end
    end

    // Stage 7: sums for the rotation about Z.
    logic signed [31:0] s7_x2_reg, s7_y2_reg, s7_z2_reg;

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_x2_reg <= q30_trunc(66'(s6_xcz_reg) - 66'(s6_ysz_reg));
            s7_y2_reg <= q30_trunc(66'(s6_xsz_reg) + 66'(s6_ycz_reg));
            s7_z2_reg <= s6_z2_reg;
        end
    end

    // Stage 8: isometric products on the wrapped difference and sum.
    logic signed [31:0] iso_dif;
    logic signed [31:0] iso_sum;
    logic signed [63:0] s8_pd_reg, s8_ps_reg;
    logic signed [31:0] s8_x2_reg, s8_y2_reg, s8_z2_reg;

    assign iso_dif = s7_x2_reg - s7_y2_reg;
    assign iso_sum = s7_x2_reg + s7_y2_reg;

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_pd_reg <= mul_s32(iso_dif, ISO_COS_Q30);
            s8_ps_reg <= mul_s32(iso_sum, ISO_SIN_Q30);
            s8_x2_reg <= s7_x2_reg;
            s8_y2_reg <= s7_y2_reg;
            s8_z2_reg <= s7_z2_reg;
        end
    end

    // Stage 9: finish the projection, or pass the rotated point when it is off.
    logic signed [31:0] s9_x_reg, s9_y_reg, s9_z2_reg;

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            if (iso_reg)
            begin
                s9_x_reg <= q30_trunc(66'(s8_pd_reg));
                s9_y_reg <= q30_trunc(66'(s8_ps_reg) - (66'(s8_z2_reg) <<< 30));
            end
            else
            begin
                s9_x_reg <= s8_x2_reg;
                s9_y_reg <= s8_y2_reg;
            end
            s9_z2_reg <= s8_z2_reg;
        end
    end

    // Stage 10: screen offset; these registers drive the result channel.
    logic signed [31:0] s10_x_reg, s10_y_reg, s10_z2_reg;

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            s10_x_reg  <= s9_x_reg + signed'(xoff_reg);
            s10_y_reg  <= s9_y_reg + signed'(yoff_reg);
            s10_z2_reg <= s9_z2_reg;
        end
    end

    assign result.valid               = v_reg[NUM_STAGES-1];
    assign result.screen_x            = s10_x_reg;
    assign result.screen_y            = s10_y_reg;
    assign result.depth               = s10_z2_reg;
    assign result.color_out           = color_reg[NUM_STAGES-1];
    assign result.needs_default_color = (color_reg[NUM_STAGES-1] == 24'd0);

endmodule
